@@ src/tccs_pkg.sv @@
// shared types and constants for the text console with cursor and scroll
// request and result structs, sequencer states, character and register codes
// no dependencies
package tccs_pkg;

    // cell layout: attribute in the high byte, character in the low byte
    localparam int CELL_W = 16;

    // control characters
    localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
    localparam logic [7:0] CHAR_RETURN    = 8'h0D;
    localparam logic [7:0] CHAR_BACKSPACE = 8'h08;
    localparam logic [7:0] CHAR_SPACE     = 8'h20;

    // request kinds
    localparam logic KIND_PUT  = 1'b0;
    localparam logic KIND_READ = 1'b1;

    // configuration registers
    localparam logic REG_TEXT_ATTR = 1'b0;
    localparam logic [7:0] TEXT_ATTR_RESET = 8'h07;

    typedef struct packed {
        logic       kind;
        logic [7:0] char_code;
        logic [6:0] read_col;
        logic [4:0] read_row;
    } in_item_t;

    typedef struct packed {
        logic [6:0] cursor_col;
        logic [4:0] cursor_row;
        logic       scrolled;
        logic [7:0] cell_char;
        logic [7:0] cell_attr;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PUT,
        ST_COPY_RD,
        ST_COPY_WR,
        ST_BLANK,
        ST_RD_ISSUE,
        ST_RD_WAIT,
        ST_DONE
    } state_t;

    // write port of the screen store
    typedef struct packed {
        logic              en;
        logic [CELL_W-1:0] data;
    } cell_wr_t;

endpackage

@@ src/tccs_screen_ram.sv @@
// screen store: one write port and one registered read port
// depends on tccs_pkg for the cell width and the write struct
module tccs_screen_ram
    import tccs_pkg::*;
#(
    parameter int DEPTH  = 2000,
    parameter int ADDR_W = 11
)
(
    input  logic                clk,
    input  cell_wr_t            wr,
    input  logic [ADDR_W-1:0]   waddr,
    input  logic [ADDR_W-1:0]   raddr,
    output logic [CELL_W-1:0]   rdata
);

    logic [CELL_W-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[waddr] <= wr.data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

@@ src/text_console_cursor_scroll.sv @@
// Text console of COLUMNS x ROWS cells with a cursor, built around one screen store
// (one write and one registered read port) and a small sequencer with a shared
// address adder. After reset a clearing pass writes zero to every cell, during which
// no request is accepted; configuration writes are taken at any time. A read request
// passes through address multiply at acceptance, store read, cell capture and result
// load. A put without scroll passes through acceptance, store write and cursor update,
// and result load. A put that scrolls adds a row copy, a store read and a store write
// per cell over the single store port pair, then blanks the last row. One request is
// in work at a time; a finished result waits in the output register while the next
// request is accepted.
// depends on tccs_pkg and tccs_screen_ram
module text_console_cursor_scroll
    import tccs_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
)
(
    input  logic        clk,
    input  logic        rst_n,
    // request channel
    input  logic        in_valid,
    output logic        in_stall,
    input  in_item_t    in_data,
    // result channel
    output logic        out_valid,
    input  logic        out_stall,
    output out_item_t   out_data,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);

    localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] LAST_BASE = ADDR_W'((ROWS - 1) * COLUMNS);
    localparam logic [ADDR_W-1:0] COPY_END  = ADDR_W'((ROWS - 1) * COLUMNS - 1);
    localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(COLUMNS);
    localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(ROWS - 1);

    state_t state_reg, state_next;

    logic [7:0]        attr_reg;
    logic [ADDR_W-1:0] ptr_reg;
    logic [COL_W-1:0]  cur_col_reg;
    logic [ROW_W-1:0]  cur_row_reg;
    logic [ADDR_W-1:0] cur_addr_reg;
    logic [7:0]        char_reg;
    logic              range_ok_reg;
    logic [CELL_W-1:0] cell_reg;
    logic              scrolled_reg;
    logic              out_valid_reg;
    out_item_t         out_data_reg;

    logic              in_take;
    logic              out_load;
    logic [ADDR_W-1:0] addend;
    logic [ADDR_W-1:0] ptr_sum;
    cell_wr_t          wr;
    logic [ADDR_W-1:0] waddr;
    logic [ADDR_W-1:0] raddr;
    logic [CELL_W-1:0] rdata;

    logic              is_nl;
    logic              is_cr;
    logic              is_bs;
    logic              bs_ok;
    logic              put_norm;
    logic              at_right;
    logic              at_bottom;
    logic              scroll_now;
    logic [ADDR_W-1:0] nl_addr;
    logic [ADDR_W-1:0] cr_addr;
    logic [ADDR_W-1:0] dec_addr;
    logic [ADDR_W-1:0] inc_addr;

    // configuration port
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg <= TEXT_ATTR_RESET;
        end
        else if (psel && penable && pwrite && (paddr[2] == REG_TEXT_ATTR))
        begin
            attr_reg <= pwdata[7:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_TEXT_ATTR)
        begin
            prdata = {24'd0, attr_reg};
        end
    end

    // put decode
    assign is_nl      = (char_reg == CHAR_NEWLINE);
    assign is_cr      = (char_reg == CHAR_RETURN);
    assign is_bs      = (char_reg == CHAR_BACKSPACE);
    assign bs_ok      = is_bs && (cur_col_reg != '0);
    assign put_norm   = !is_nl && !is_cr && !is_bs;
    assign at_right   = (cur_col_reg == LAST_COL);
    assign at_bottom  = (cur_row_reg == LAST_ROW);
    assign scroll_now = at_bottom && (is_nl || (put_norm && at_right));

    // cursor address arithmetic
    assign cr_addr  = cur_addr_reg - ADDR_W'(cur_col_reg);
    assign nl_addr  = cr_addr + ROW_STEP;
    assign dec_addr = cur_addr_reg - ADDR_W'(1);
    assign inc_addr = cur_addr_reg + ADDR_W'(1);

    // shared pointer adder: row offset while copying, one step otherwise
    assign ptr_sum = ptr_reg + addend;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (ptr_reg == LAST_CELL)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (in_data.kind == KIND_READ) ? ST_RD_ISSUE : ST_PUT;
                end
            end
            ST_PUT:
            begin
                state_next = scroll_now ? ST_COPY_RD : ST_DONE;
            end
            ST_COPY_RD:
            begin
                state_next = ST_COPY_WR;
            end
            ST_COPY_WR:
            begin
                state_next = (ptr_reg == COPY_END) ? ST_BLANK : ST_COPY_RD;
            end
            ST_BLANK:
            begin
                if (ptr_reg == LAST_CELL)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_RD_ISSUE:
            begin
                state_next = ST_RD_WAIT;
            end
            ST_RD_WAIT:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_stall = 1'b1;
        out_load = 1'b0;
        addend   = ADDR_W'(1);
        raddr    = ptr_reg;
        waddr    = ptr_reg;
        wr.en    = 1'b0;
        wr.data  = {attr_reg, CHAR_SPACE};
        unique case (state_reg)
            ST_CLEAR:
            begin
                wr.en   = 1'b1;
                wr.data = '0;
            end
            ST_IDLE:
            begin
                in_stall = 1'b0;
            end
            ST_PUT:
            begin
                if (put_norm)
                begin
                    wr.en   = 1'b1;
                    waddr   = cur_addr_reg;
                    wr.data = {attr_reg, char_reg};
                end
                else if (bs_ok)
                begin
                    wr.en = 1'b1;
                    waddr = dec_addr;
                end
            end
            ST_COPY_RD:
            begin
                addend = ROW_STEP;
                raddr  = ptr_sum;
            end
            ST_COPY_WR:
            begin
                wr.en   = 1'b1;
                wr.data = rdata;
            end
            ST_BLANK:
            begin
                wr.en = 1'b1;
            end
            ST_RD_ISSUE, ST_RD_WAIT:
            begin
            end
            ST_DONE:
            begin
                out_load = !out_valid_reg || !out_stall;
            end
            default:
            begin
            end
        endcase
    end

    assign in_take = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // pointer and cursor
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg      <= '0;
            cur_col_reg  <= '0;
            cur_row_reg  <= '0;
            cur_addr_reg <= '0;
            scrolled_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_CLEAR, ST_COPY_WR, ST_BLANK:
                begin
                    ptr_reg <= ptr_sum;
                end
                ST_IDLE:
                begin
                    if (in_take)
                    begin
                        scrolled_reg <= 1'b0;
                        ptr_reg <= ADDR_W'(int'(in_data.read_row) * COLUMNS
                                           + int'(in_data.read_col));
                    end
                end
                ST_PUT:
                begin
                    ptr_reg      <= '0;
                    scrolled_reg <= scroll_now;
                    if (is_nl || (put_norm && at_right))
                    begin
                        cur_col_reg <= '0;
                        if (at_bottom)
                        begin
                            cur_addr_reg <= LAST_BASE;
                        end
                        else
                        begin
                            cur_row_reg  <= cur_row_reg + ROW_W'(1);
                            cur_addr_reg <= is_nl ? nl_addr : inc_addr;
                        end
                    end
                    else if (is_cr)
                    begin
                        cur_col_reg  <= '0;
                        cur_addr_reg <= cr_addr;
                    end
                    else if (bs_ok)
                    begin
                        cur_col_reg  <= cur_col_reg - COL_W'(1);
                        cur_addr_reg <= dec_addr;
                    end
                    else if (put_norm)
                    begin
                        cur_col_reg  <= cur_col_reg + COL_W'(1);
                        cur_addr_reg <= inc_addr;
                    end
                end
                ST_COPY_RD, ST_RD_ISSUE, ST_RD_WAIT, ST_DONE:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end

    // request payload and read cell capture
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            char_reg     <= in_data.char_code;
            range_ok_reg <= (int'(in_data.read_col) < COLUMNS)
                            && (int'(in_data.read_row) < ROWS);
            cell_reg     <= '0;
        end
        else if (state_reg == ST_RD_WAIT)
        begin
            cell_reg <= range_ok_reg ? rdata : '0;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg.cursor_col <= 7'(cur_col_reg);
            out_data_reg.cursor_row <= 5'(cur_row_reg);
            out_data_reg.scrolled   <= scrolled_reg;
            out_data_reg.cell_char  <= cell_reg[7:0];
            out_data_reg.cell_attr  <= cell_reg[15:8];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    tccs_screen_ram #(
        .DEPTH  (CELLS),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk    (clk),
        .wr     (wr),
        .waddr  (waddr),
        .raddr  (raddr),
        .rdata  (rdata)
    );

    // no request is taken during the clearing pass or the copy-read and blank states of a scroll
    a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR || state_reg == ST_COPY_RD || state_reg == ST_BLANK)
        |-> in_stall)
        else $error("request accepted while the screen store is busy");

    // linear cursor address tracks column and row
    a_cursor_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE)
        |-> (int'(cur_addr_reg) == int'(cur_row_reg) * COLUMNS + int'(cur_col_reg)))
        else $error("cursor address out of step with cursor position");

    // cursor stays on the screen
    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        (int'(cur_col_reg) < COLUMNS) && (int'(cur_row_reg) < ROWS))
        else $error("cursor off the screen");

    // a scrolled result leaves the cursor at the start of the last row
    a_scroll_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_load && scrolled_reg
        |=> (out_data.cursor_row == 5'(ROWS - 1)) && (out_data.cursor_col == 7'd0))
        else $error("scroll left the cursor in the wrong place");

    // a finished result is never dropped while the output is held
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |-> !out_load)
        else $error("result loaded over a stalled result");

endmodule
